// ----- hw/rtl/gbts_pkg.sv -----
// Shared types and codes for the gap buffer text store.
// Field widths, request kinds, status codes and the controller state type.
// No dependencies; every other file refers to it by scoped names.
package gbts_pkg;

  // Beat field widths
  localparam int KIND_W = 3;
  localparam int POS_W  = 11;
  localparam int CHAR_W = 8;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 11;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MOVE   = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  // Controller states, one-hot
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_MOVE   = 3'b010,
    S_RDWAIT = 3'b100
  } state_t;

endpackage

// ----- hw/rtl/gbts_mem.sv -----
// Character store of the gap buffer: one write port, one read port.
// Read data is registered, so it shows in the cycle after the address.
// Depends on gbts_pkg for the character width.
module gbts_mem #(
  parameter int DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(DEPTH)-1:0]        waddr,
  input  logic [gbts_pkg::CHAR_W-1:0]     wdata,
  input  logic [$clog2(DEPTH)-1:0]        raddr,
  output logic [gbts_pkg::CHAR_W-1:0]     rdata
);

  logic [gbts_pkg::CHAR_W-1:0] mem_q [DEPTH];
  logic [gbts_pkg::CHAR_W-1:0] rdata_r;

  // Write one character
  always_ff @(posedge clk) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
  end

  // Read one character, registered
  always_ff @(posedge clk) begin
    rdata_r <= mem_q[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/gap_buffer_text_store.sv -----
// Gap buffer text store: controller, gap pointers and result register.
// Depends on gbts_pkg and instantiates gbts_mem for the character store.
//
//   channel  | ports                                        | handshake
//   ---------+----------------------------------------------+-------------------------
//   request  | in_kind, in_position, in_char_in             | start high, busy low
//   result   | out_char_out, out_status, out_text_length    | out_valid, one cycle
//
// A request first moves the gap to its target, then does the edit; a read
// also waits for the store's registered read port. The moving gap costs
// one store read and one store write per character, pipelined one a cycle,
// and the edit waits until the last of those writes is retired.
// Reset (rst_n low, synchronous) empties the text; the store is not cleared.
// The receiver cannot stall: each result is strobed for one cycle.
module gap_buffer_text_store #(
  parameter int CAPACITY = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [gbts_pkg::KIND_W-1:0]     in_kind,
  input  logic [gbts_pkg::POS_W-1:0]      in_position,
  input  logic [gbts_pkg::CHAR_W-1:0]     in_char_in,
  output logic                            out_valid,
  output logic [gbts_pkg::CHAR_W-1:0]     out_char_out,
  output logic [gbts_pkg::STAT_W-1:0]     out_status,
  output logic [gbts_pkg::LEN_W-1:0]      out_text_length
);

  localparam int AW = $clog2(CAPACITY);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int CW = ((PW > gbts_pkg::POS_W) ? PW : gbts_pkg::POS_W) + 1;

  gbts_pkg::state_t state_r, state_nxt;

  logic [PW-1:0] gs_r, gs_nxt;
  logic [PW-1:0] ge_r, ge_nxt;

  // Captured request
  logic [gbts_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [gbts_pkg::CHAR_W-1:0] ch_r, ch_nxt;
  logic [CW-1:0]               tgt_r, tgt_nxt;
  logic                        err_r, err_nxt;

  // Pending move write
  logic          wpend_r, wpend_nxt;
  logic [AW-1:0] waddr_r, waddr_nxt;

  // Result register
  logic                        ov_r, ov_nxt;
  logic [gbts_pkg::CHAR_W-1:0] oc_r, oc_nxt;
  logic [gbts_pkg::STAT_W-1:0] os_r, os_nxt;
  logic [gbts_pkg::LEN_W-1:0]  ol_r, ol_nxt;

  // Store ports
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [gbts_pkg::CHAR_W-1:0] mem_wdata;
  logic [AW-1:0]               mem_raddr;
  logic [gbts_pkg::CHAR_W-1:0] mem_rdata;

  logic [PW-1:0] len_cur;
  logic [CW-1:0] len_ext;
  logic [CW-1:0] pos_ext;
  logic [CW-1:0] gs_ext;
  logic [PW-1:0] gs_dec;
  logic [PW-1:0] ge_dec;
  logic [PW-1:0] len_nxt;
  logic [CW-1:0] len_nxt_ext;
  logic          accept;

  gbts_mem #(
    .DEPTH (CAPACITY)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy   = (state_r != gbts_pkg::S_IDLE);
  assign accept = start && !busy;

  assign len_cur = PW'(CAPACITY) - (ge_r - gs_r);
  assign len_ext = CW'(len_cur);
  assign pos_ext = CW'(in_position);
  assign gs_ext  = CW'(gs_r);
  assign gs_dec  = gs_r - PW'(1);
  assign ge_dec  = ge_r - PW'(1);

  assign len_nxt     = PW'(CAPACITY) - (ge_nxt - gs_nxt);
  assign len_nxt_ext = CW'(len_nxt);

  // Sequence moves and the edit itself
  always_comb begin
    state_nxt = state_r;
    gs_nxt    = gs_r;
    ge_nxt    = ge_r;
    kind_nxt  = kind_r;
    ch_nxt    = ch_r;
    tgt_nxt   = tgt_r;
    err_nxt   = err_r;
    wpend_nxt = 1'b0;
    waddr_nxt = waddr_r;
    ov_nxt    = 1'b0;
    oc_nxt    = oc_r;
    os_nxt    = os_r;
    ol_nxt    = ol_r;
    mem_raddr = ge_r[AW-1:0];
    mem_we    = wpend_r;
    mem_waddr = waddr_r;
    mem_wdata = mem_rdata;

    case (state_r)
      gbts_pkg::S_IDLE: begin
        if (accept) begin
          kind_nxt = in_kind;
          ch_nxt   = in_char_in;
          // Range check against the current length
          case (in_kind)
            gbts_pkg::KIND_INSERT,
            gbts_pkg::KIND_MOVE: err_nxt = (pos_ext > len_ext);
            gbts_pkg::KIND_DELETE,
            gbts_pkg::KIND_READ,
            gbts_pkg::KIND_WRITE: err_nxt = (pos_ext >= len_ext);
            default: err_nxt = 1'b0;
          endcase
          // Gap target; no move on error or unused kinds
          case (in_kind)
            gbts_pkg::KIND_DELETE: tgt_nxt = pos_ext + CW'(1);
            gbts_pkg::KIND_INSERT,
            gbts_pkg::KIND_MOVE,
            gbts_pkg::KIND_READ,
            gbts_pkg::KIND_WRITE: tgt_nxt = pos_ext;
            default: tgt_nxt = gs_ext;
          endcase
          if (err_nxt) begin
            tgt_nxt = gs_ext;
          end
          state_nxt = gbts_pkg::S_MOVE;
        end
      end

      gbts_pkg::S_MOVE: begin
        if (gs_ext > tgt_r) begin
          // Shift one character from before the gap to its end
          mem_raddr = gs_dec[AW-1:0];
          waddr_nxt = ge_dec[AW-1:0];
          wpend_nxt = 1'b1;
          gs_nxt    = gs_dec;
          ge_nxt    = ge_dec;
        end else if (gs_ext < tgt_r) begin
          // Shift one character from after the gap to its start
          mem_raddr = ge_r[AW-1:0];
          waddr_nxt = gs_r[AW-1:0];
          wpend_nxt = 1'b1;
          gs_nxt    = gs_r + PW'(1);
          ge_nxt    = ge_r + PW'(1);
        end else if (!wpend_r) begin
          // Gap in place and store settled: do the edit
          os_nxt = gbts_pkg::ST_OK;
          oc_nxt = '0;
          ov_nxt = 1'b1;
          state_nxt = gbts_pkg::S_IDLE;
          if (err_r) begin
            os_nxt = gbts_pkg::ST_RANGE;
          end else begin
            case (kind_r)
              gbts_pkg::KIND_INSERT: begin
                if (gs_r == ge_r) begin
                  os_nxt = gbts_pkg::ST_FULL;
                end else begin
                  mem_we    = 1'b1;
                  mem_waddr = gs_r[AW-1:0];
                  mem_wdata = ch_r;
                  gs_nxt    = gs_r + PW'(1);
                end
              end
              gbts_pkg::KIND_DELETE: begin
                gs_nxt = gs_dec;
              end
              gbts_pkg::KIND_WRITE: begin
                mem_we    = 1'b1;
                mem_waddr = ge_r[AW-1:0];
                mem_wdata = ch_r;
              end
              gbts_pkg::KIND_READ: begin
                ov_nxt    = 1'b0;
                state_nxt = gbts_pkg::S_RDWAIT;
              end
              default: begin
              end
            endcase
          end
        end
        ol_nxt = len_nxt_ext[gbts_pkg::LEN_W-1:0];
      end

      gbts_pkg::S_RDWAIT: begin
        // Return the character read at the gap end
        oc_nxt    = mem_rdata;
        os_nxt    = gbts_pkg::ST_OK;
        ol_nxt    = len_ext[gbts_pkg::LEN_W-1:0];
        ov_nxt    = 1'b1;
        state_nxt = gbts_pkg::S_IDLE;
      end

      default: begin
        state_nxt = gbts_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbts_pkg::S_IDLE;
      gs_r    <= '0;
      ge_r    <= PW'(CAPACITY);
      wpend_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      gs_r    <= gs_nxt;
      ge_r    <= ge_nxt;
      wpend_r <= wpend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    ch_r    <= ch_nxt;
    tgt_r   <= tgt_nxt;
    err_r   <= err_nxt;
    waddr_r <= waddr_nxt;
    oc_r    <= oc_nxt;
    os_r    <= os_nxt;
    ol_r    <= ol_nxt;
  end

  assign out_valid       = ov_r;
  assign out_char_out    = oc_r;
  assign out_status      = os_r;
  assign out_text_length = ol_r;

endmodule

// ----- hw/rtl/gbts_checker.sv -----
// Port-level checks for the gap buffer text store, bound to the top level.
// Depends on gbts_pkg for status codes.
// Watches the request/result handshake and result fields over time.
module gbts_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic [gbts_pkg::CHAR_W-1:0] out_char_out,
  input logic [gbts_pkg::STAT_W-1:0] out_status
);

  // An accepted beat makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  // A result is strobed only once the block is free again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while busy");

  // Leaving busy always delivers a result
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("busy dropped without a result");

  // Failed requests return no character, and every result has a defined status
  a_fail_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == gbts_pkg::ST_FULL || out_status == gbts_pkg::ST_RANGE)
      |-> out_char_out == '0)
    else $error("failed request returned a character");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == gbts_pkg::ST_OK || out_status == gbts_pkg::ST_FULL ||
                   out_status == gbts_pkg::ST_RANGE))
    else $error("undefined status code");

endmodule

bind gap_buffer_text_store gbts_checker u_gbts_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_char_out (out_char_out),
  .out_status   (out_status)
);
